/* rtl/tpdm_pkg.sv */
`default_nettype none
package tpdm_pkg;

    localparam int VoltW  = 15;
    localparam int GainW  = 12;
    localparam int InjW   = 14;
    localparam int PhW    = 16;
    localparam int DutyW  = 15;
    localparam int OffW   = 10;
    localparam int CfgIdxW = 2;
    localparam int Lanes  = 3;

    localparam logic [OffW-1:0]  OffsetReset = OffW'(20);
    localparam logic [DutyW-1:0] MaxReset    = DutyW'(32767);
    localparam logic [DutyW-1:0] MinReset    = DutyW'(0);

    typedef enum logic [CfgIdxW-1:0] {
        REG_DUTY_OFFSET = 2'd0,
        REG_DUTY_MAX    = 2'd1,
        REG_DUTY_MIN    = 2'd2
    } tpdm_reg_idx_t;

    typedef enum logic [1:0] {
        MODE_SINE   = 2'd0,
        MODE_MINMAX = 2'd1,
        MODE_DPWM   = 2'd2
    } tpdm_mode_t;

    typedef struct packed {
        logic [OffW-1:0]  duty_offset;
        logic [DutyW-1:0] duty_max;
        logic [DutyW-1:0] duty_min;
    } tpdm_cfg_t;

endpackage
`default_nettype wire

/* rtl/tpdm_scale_lane.sv */
`default_nettype none
module tpdm_scale_lane (
    input  wire logic                                 aclk,
    input  wire logic                                 en,
    input  wire logic signed [tpdm_pkg::VoltW-1:0]    x,
    input  wire logic        [tpdm_pkg::GainW-1:0]    gain,
    output logic      signed [tpdm_pkg::PhW-1:0]      y
);
    import tpdm_pkg::*;

    localparam int ProdW = VoltW + GainW + 1;

    logic signed [ProdW-1:0] prod;
    logic signed [PhW-1:0]   y_reg;

    // (x*gain)>>>12, kept to 16 bits
    assign prod = ProdW'(x * $signed({1'b0, gain}));

    always_ff @(posedge aclk) begin
        if (en) begin
            y_reg <= prod[PhW+GainW-1:GainW];
        end
    end

    assign y = y_reg;
endmodule
`default_nettype wire

/* rtl/tpdm_merge.sv */
`default_nettype none
module tpdm_merge (
    input  wire logic        [1:0]                    mode,
    input  wire logic signed [tpdm_pkg::PhW-1:0]      p   [tpdm_pkg::Lanes],
    input  wire logic signed [tpdm_pkg::PhW-1:0]      inj [tpdm_pkg::Lanes],
    input  wire logic signed [tpdm_pkg::InjW-1:0]     dr,
    input  wire logic signed [tpdm_pkg::InjW-1:0]     ds,
    input  wire logic        [tpdm_pkg::DutyW-1:0]    duty_max,
    output logic      signed [tpdm_pkg::PhW-1:0]      common,
    output logic      signed [tpdm_pkg::PhW-1:0]      extra [tpdm_pkg::Lanes]
);
    import tpdm_pkg::*;

    logic signed [PhW-1:0] mn, mx, mid, sel, dmax;
    logic signed [PhW:0]   sum;
    logic        [PhW:0]   mag  [Lanes];
    logic        [PhW:0]   best;

    always_comb begin
        for (int i = 0; i < Lanes; i++) begin
            mag[i] = p[i][PhW-1] ? (PhW+1)'(-{p[i][PhW-1], p[i]}) : {1'b0, p[i]};
        end

        mn = p[0];
        mx = p[0];
        for (int i = 1; i < Lanes; i++) begin
            if (p[i] > mx) mx = p[i];
            if (p[i] < mn) mn = p[i];
        end
        sum = {mn[PhW-1], mn} + {mx[PhW-1], mx};
        mid = sum[PhW:1];

        // largest magnitude, ties keep the earlier phase
        sel  = p[0];
        best = mag[0];
        for (int i = 1; i < Lanes; i++) begin
            if (best < mag[i]) begin
                best = mag[i];
                sel  = p[i];
            end
        end
        dmax = $signed({1'b0, duty_max});

        unique case (mode)
            MODE_MINMAX: begin
                common   = -mid;
                extra[0] = inj[0];
                extra[1] = inj[1];
                extra[2] = -inj[2];
            end
            MODE_DPWM: begin
                common   = (!sel[PhW-1] && sel != '0) ? dmax - sel : -dmax - sel;
                extra[0] = PhW'(dr);
                extra[1] = PhW'(ds);
                extra[2] = '0;
            end
            default: begin
                common   = '0;
                extra[0] = '0;
                extra[1] = '0;
                extra[2] = '0;
            end
        endcase
    end
endmodule
`default_nettype wire

/* rtl/tpdm_split_lane.sv */
`default_nettype none
module tpdm_split_lane (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 en,
    input  wire tpdm_pkg::tpdm_cfg_t                  cfg,
    input  wire logic signed [tpdm_pkg::PhW-1:0]      p,
    input  wire logic signed [tpdm_pkg::PhW-1:0]      common,
    input  wire logic signed [tpdm_pkg::PhW-1:0]      extra,
    output logic             [tpdm_pkg::DutyW-1:0]    duty_pos,
    output logic             [tpdm_pkg::DutyW-1:0]    duty_neg
);
    import tpdm_pkg::*;

    logic signed [PhW-1:0]   m;
    logic                    is_neg;
    logic        [PhW-1:0]   magn, act;
    logic        [PhW:0]     d_sum, d_clip;
    logic        [DutyW-1:0] d;
    logic                    prev_neg_reg;
    logic        [DutyW-1:0] pos_reg, neg_reg;

    always_comb begin
        m      = p + common + extra;
        is_neg = m[PhW-1];
        magn   = is_neg ? PhW'(-m) : PhW'(m);
        // first item after a sign change starts from zero magnitude
        act    = (is_neg == prev_neg_reg) ? magn : '0;
        d_sum  = {1'b0, act} + (PhW+1)'(cfg.duty_offset);
        d_clip = d_sum;
        if (d_clip > (PhW+1)'(cfg.duty_max)) d_clip = (PhW+1)'(cfg.duty_max);
        if (d_clip < (PhW+1)'(cfg.duty_min)) d_clip = (PhW+1)'(cfg.duty_min);
        d = d_clip[DutyW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_neg_reg <= 1'b0;
        end else if (en) begin
            prev_neg_reg <= is_neg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pos_reg <= is_neg ? '0 : d;
            neg_reg <= is_neg ? d : '0;
        end
    end

    assign duty_pos = pos_reg;
    assign duty_neg = neg_reg;
endmodule
`default_nettype wire

/* rtl/three_phase_pwm_duty_modulator_top.sv */
`default_nettype none
// Three-phase PWM duty modulator. Takes one request per cycle and returns one
// set of six leg compare values. It has a gain multiply lane per phase and per
// injection term, a merge stage that forms the common-mode and injection terms
// for the chosen mode, and a split lane per phase that adds them, applies the
// sign-change blanking, the offset and the min/max clamp. The pipeline holds
// under output backpressure and fills its bubbles, so the sustained rate is
// one request per cycle with m_ready high. Configuration writes (offset, max,
// min) take effect at once and must only be made while the pipeline is empty.
module three_phase_pwm_duty_modulator_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [tpdm_pkg::CfgIdxW-1:0]        cfg_addr,
    input  wire logic [tpdm_pkg::DutyW-1:0]          cfg_wdata,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [1:0]                          s_mode,
    input  wire logic signed [tpdm_pkg::VoltW-1:0]   s_phase_r_volt,
    input  wire logic signed [tpdm_pkg::VoltW-1:0]   s_phase_s_volt,
    input  wire logic signed [tpdm_pkg::VoltW-1:0]   s_phase_t_volt,
    input  wire logic [tpdm_pkg::GainW-1:0]          s_pwm_gain,
    input  wire logic signed [tpdm_pkg::InjW-1:0]    s_dc_inject_r,
    input  wire logic signed [tpdm_pkg::InjW-1:0]    s_dc_inject_s,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [tpdm_pkg::DutyW-1:0]               m_r_duty_pos,
    output logic [tpdm_pkg::DutyW-1:0]               m_r_duty_neg,
    output logic [tpdm_pkg::DutyW-1:0]               m_s_duty_pos,
    output logic [tpdm_pkg::DutyW-1:0]               m_s_duty_neg,
    output logic [tpdm_pkg::DutyW-1:0]               m_t_duty_pos,
    output logic [tpdm_pkg::DutyW-1:0]               m_t_duty_neg
);
    import tpdm_pkg::*;

    tpdm_cfg_t cfg_reg;

    logic v1_reg, v2_reg, v3_reg;
    logic adv1, adv2, adv3;

    logic signed [VoltW-1:0] lane_x [2*Lanes];
    logic signed [PhW-1:0]   lane_y [2*Lanes];
    logic signed [PhW-1:0]   p1     [Lanes];
    logic signed [PhW-1:0]   inj1   [Lanes];
    logic [1:0]              mode1_reg;
    logic signed [InjW-1:0]  dr1_reg, ds1_reg;

    logic signed [PhW-1:0]   common;
    logic signed [PhW-1:0]   extra   [Lanes];
    logic signed [PhW-1:0]   p2_reg  [Lanes];
    logic signed [PhW-1:0]   e2_reg  [Lanes];
    logic signed [PhW-1:0]   c2_reg;

    logic [DutyW-1:0] duty_pos [Lanes];
    logic [DutyW-1:0] duty_neg [Lanes];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.duty_offset <= OffsetReset;
            cfg_reg.duty_max    <= MaxReset;
            cfg_reg.duty_min    <= MinReset;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_DUTY_OFFSET: cfg_reg.duty_offset <= cfg_wdata[OffW-1:0];
                REG_DUTY_MAX:    cfg_reg.duty_max    <= cfg_wdata;
                REG_DUTY_MIN:    cfg_reg.duty_min    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // each stage moves when it is empty or the next one moves
    assign adv3    = !v3_reg || m_ready;
    assign adv2    = !v2_reg || adv3;
    assign adv1    = !v1_reg || adv2;
    assign s_ready = adv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
    end

    assign lane_x[0] = s_phase_r_volt;
    assign lane_x[1] = s_phase_s_volt;
    assign lane_x[2] = s_phase_t_volt;
    assign lane_x[3] = VoltW'(s_dc_inject_r);
    assign lane_x[4] = VoltW'(s_dc_inject_s);
    assign lane_x[5] = VoltW'(s_dc_inject_r) + VoltW'(s_dc_inject_s);

    for (genvar g = 0; g < 2*Lanes; g++) begin : g_scale
        tpdm_scale_lane u_scale (
            .aclk (aclk),
            .en   (adv1),
            .x    (lane_x[g]),
            .gain (s_pwm_gain),
            .y    (lane_y[g])
        );
    end

    for (genvar g = 0; g < Lanes; g++) begin : g_map
        assign p1[g]   = lane_y[g];
        assign inj1[g] = lane_y[Lanes+g];
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            mode1_reg <= s_mode;
            dr1_reg   <= s_dc_inject_r;
            ds1_reg   <= s_dc_inject_s;
        end
    end

    tpdm_merge u_merge (
        .mode     (mode1_reg),
        .p        (p1),
        .inj      (inj1),
        .dr       (dr1_reg),
        .ds       (ds1_reg),
        .duty_max (cfg_reg.duty_max),
        .common   (common),
        .extra    (extra)
    );

    always_ff @(posedge aclk) begin
        if (adv2) begin
            c2_reg <= common;
            for (int i = 0; i < Lanes; i++) begin
                p2_reg[i] <= p1[i];
                e2_reg[i] <= extra[i];
            end
        end
    end

    for (genvar g = 0; g < Lanes; g++) begin : g_split
        tpdm_split_lane u_split (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (adv3 && v2_reg),
            .cfg      (cfg_reg),
            .p        (p2_reg[g]),
            .common   (c2_reg),
            .extra    (e2_reg[g]),
            .duty_pos (duty_pos[g]),
            .duty_neg (duty_neg[g])
        );
    end

    assign m_valid      = v3_reg;
    assign m_r_duty_pos = duty_pos[0];
    assign m_r_duty_neg = duty_neg[0];
    assign m_s_duty_pos = duty_pos[1];
    assign m_s_duty_neg = duty_neg[1];
    assign m_t_duty_pos = duty_pos[2];
    assign m_t_duty_neg = duty_neg[2];

endmodule
`default_nettype wire

/* bench/tb_top.sv */
module tb_top;
    import tpdm_pkg::*;

    localparam int Latency     = 3;
    localparam int GainShift   = 12;
    localparam int HoldCycles  = 300;
    localparam int DrainLimit  = 5000;
    localparam int LimitCycles = 1000000;
    localparam int PrintCap    = 40;
    localparam int PhaseCount  = 6;
    localparam int PhaseItems  = 310;
    localparam int VoltMax     = 2**(VoltW-1) - 1;
    localparam int VoltMin     = -(2**(VoltW-1));
    localparam int InjMax      = 2**(InjW-1) - 1;
    localparam int InjMin      = -(2**(InjW-1));
    localparam int GainMax     = 2**GainW - 1;
    localparam int DutyMax     = 2**DutyW - 1;
    localparam int OffMax      = 2**OffW - 1;
    // mode code 3 has no name in the package; the block treats it as sine
    localparam logic [1:0] ModeSineAlt = 2'd3;

    typedef struct {
        logic [1:0]              mode;
        logic signed [VoltW-1:0] vr;
        logic signed [VoltW-1:0] vs;
        logic signed [VoltW-1:0] vt;
        logic [GainW-1:0]        gain;
        logic signed [InjW-1:0]  dr;
        logic signed [InjW-1:0]  ds;
    } mod_req_t;

    typedef struct {
        logic [DutyW-1:0] r_pos;
        logic [DutyW-1:0] r_neg;
        logic [DutyW-1:0] s_pos;
        logic [DutyW-1:0] s_neg;
        logic [DutyW-1:0] t_pos;
        logic [DutyW-1:0] t_neg;
    } duty_set_t;

    logic                    aclk           = 1'b0;
    logic                    aresetn        = 1'b0;
    logic                    cfg_we         = 1'b0;
    logic [CfgIdxW-1:0]      cfg_addr       = '0;
    logic [DutyW-1:0]        cfg_wdata      = '0;
    logic                    s_valid        = 1'b0;
    logic                    s_ready;
    logic [1:0]              s_mode         = '0;
    logic signed [VoltW-1:0] s_phase_r_volt = '0;
    logic signed [VoltW-1:0] s_phase_s_volt = '0;
    logic signed [VoltW-1:0] s_phase_t_volt = '0;
    logic [GainW-1:0]        s_pwm_gain     = '0;
    logic signed [InjW-1:0]  s_dc_inject_r  = '0;
    logic signed [InjW-1:0]  s_dc_inject_s  = '0;
    logic                    m_valid;
    logic                    m_ready        = 1'b0;
    logic [DutyW-1:0]        m_r_duty_pos;
    logic [DutyW-1:0]        m_r_duty_neg;
    logic [DutyW-1:0]        m_s_duty_pos;
    logic [DutyW-1:0]        m_s_duty_neg;
    logic [DutyW-1:0]        m_t_duty_pos;
    logic [DutyW-1:0]        m_t_duty_neg;

    duty_set_t expected_duties[$];
    int        err_count    = 0;
    int        results_seen = 0;
    bit        tx_idle_en   = 1'b1;
    bit        rx_idle_en   = 1'b1;
    int        hold_req     = 0;

    // predictor copy of the registers and the per-phase sign history
    int        cfg_offset    = OffsetReset;
    int        cfg_max       = MaxReset;
    int        cfg_min       = MinReset;
    logic [2:0] phase_was_neg = '0;

    three_phase_pwm_duty_modulator_top u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_phase_r_volt (s_phase_r_volt),
        .s_phase_s_volt (s_phase_s_volt),
        .s_phase_t_volt (s_phase_t_volt),
        .s_pwm_gain     (s_pwm_gain),
        .s_dc_inject_r  (s_dc_inject_r),
        .s_dc_inject_s  (s_dc_inject_s),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_r_duty_pos   (m_r_duty_pos),
        .m_r_duty_neg   (m_r_duty_neg),
        .m_s_duty_pos   (m_s_duty_pos),
        .m_s_duty_neg   (m_s_duty_neg),
        .m_t_duty_pos   (m_t_duty_pos),
        .m_t_duty_neg   (m_t_duty_neg)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int wrap16(input int x);
        return {{16{x[15]}}, x[15:0]};
    endfunction

    function automatic int scale_by_gain(input int x, input int g);
        return wrap16((x * g) >>> GainShift);
    endfunction

    function automatic void split_leg(input int m, input int idx,
                                      output logic [DutyW-1:0] pos,
                                      output logic [DutyW-1:0] neg);
        bit was_neg;
        int d;
        was_neg = phase_was_neg[idx];
        // first sample after a sign flip is blanked to zero magnitude
        if (m >= 0) d = was_neg ? 0 : m;
        else        d = was_neg ? -m : 0;
        d = d + cfg_offset;
        if (d > cfg_max) d = cfg_max;
        if (d < cfg_min) d = cfg_min;
        if (m >= 0) begin
            pos = d[DutyW-1:0];
            neg = '0;
            phase_was_neg[idx] = 1'b0;
        end else begin
            pos = '0;
            neg = d[DutyW-1:0];
            phase_was_neg[idx] = 1'b1;
        end
    endfunction

    function automatic duty_set_t predict_duties(input mod_req_t r);
        duty_set_t res;
        int g, dr, ds, lo, hi, mid, sel, best, k;
        int p[3];
        int m[3];
        g  = r.gain;
        dr = r.dr;
        ds = r.ds;
        p[0] = scale_by_gain(r.vr, g);
        p[1] = scale_by_gain(r.vs, g);
        p[2] = scale_by_gain(r.vt, g);
        case (r.mode)
            MODE_MINMAX: begin
                lo = p[0];
                hi = p[0];
                for (int i = 1; i < 3; i++) begin
                    if (p[i] > hi) hi = p[i];
                    if (p[i] < lo) lo = p[i];
                end
                mid  = (lo + hi) >>> 1;
                m[0] = wrap16(p[0] - mid + scale_by_gain(dr, g));
                m[1] = wrap16(p[1] - mid + scale_by_gain(ds, g));
                m[2] = wrap16(p[2] - mid - scale_by_gain(wrap16(dr + ds), g));
            end
            MODE_DPWM: begin
                sel  = p[0];
                best = (p[0] < 0) ? -p[0] : p[0];
                // strict compare: on equal magnitude the earlier phase wins
                for (int i = 1; i < 3; i++) begin
                    if (best < ((p[i] < 0) ? -p[i] : p[i])) begin
                        best = (p[i] < 0) ? -p[i] : p[i];
                        sel  = p[i];
                    end
                end
                k    = (sel > 0) ? cfg_max - sel : -cfg_max - sel;
                m[0] = wrap16(p[0] + k + dr);
                m[1] = wrap16(p[1] + k + ds);
                m[2] = wrap16(p[2] + k);
            end
            default: begin
                m = p;
            end
        endcase
        split_leg(m[0], 0, res.r_pos, res.r_neg);
        split_leg(m[1], 1, res.s_pos, res.s_neg);
        split_leg(m[2], 2, res.t_pos, res.t_neg);
        return res;
    endfunction

    // ------------------------------------------------------------ random helpers

    function automatic int rand_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        if (pick < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // full range, extremes, or values near zero so signs flip often
    function automatic int rand_signed(input int w);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return -(2**(w-1));
        if (pick == 1) return 2**(w-1) - 1;
        if (pick < 4)  return int'($urandom_range(0, 400)) - 200;
        return $urandom_range(0, 2**w - 1);
    endfunction

    function automatic int rand_gain();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 0;
        if (pick < 3)  return GainMax;
        if (pick == 3) return $urandom_range(1, 64);
        return $urandom_range(0, GainMax);
    endfunction

    function automatic mod_req_t random_req();
        mod_req_t r;
        r.mode = 2'($urandom_range(0, 3));
        r.vr   = VoltW'(rand_signed(VoltW));
        r.vs   = VoltW'(rand_signed(VoltW));
        r.vt   = VoltW'(rand_signed(VoltW));
        r.gain = GainW'(rand_gain());
        r.dr   = InjW'(rand_signed(InjW));
        r.ds   = InjW'(rand_signed(InjW));
        return r;
    endfunction

    // ------------------------------------------------------------------ driving

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= PrintCap) $display("%0t: %s", $time, what);
    endtask

    // caller sits on a clock edge where s_valid got no other update
    task automatic send_req(input mod_req_t r);
        int gap;
        gap = tx_idle_en ? rand_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_mode         <= r.mode;
        s_phase_r_volt <= r.vr;
        s_phase_s_volt <= r.vs;
        s_phase_t_volt <= r.vt;
        s_pwm_gain     <= r.gain;
        s_dc_inject_r  <= r.dr;
        s_dc_inject_s  <= r.ds;
        do @(posedge aclk); while (!s_ready);
        expected_duties.push_back(predict_duties(r));
    endtask

    task automatic send_fields(input logic [1:0] mode, input int vr, input int vs,
                               input int vt, input int gain, input int dr, input int ds);
        mod_req_t r;
        r.mode = mode;
        r.vr   = VoltW'(vr);
        r.vs   = VoltW'(vs);
        r.vt   = VoltW'(vt);
        r.gain = GainW'(gain);
        r.dr   = InjW'(dr);
        r.ds   = InjW'(ds);
        send_req(r);
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        while (expected_duties.size() != 0 && waited < DrainLimit) begin
            @(posedge aclk);
            waited++;
        end
        if (expected_duties.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_duties.size()));
            expected_duties.delete();
        end
        repeat (Latency + 2) @(posedge aclk);
    endtask

    task automatic close_phase();
        s_valid <= 1'b0;
        drain_results();
    endtask

    // only called with the pipeline empty
    task automatic set_config(input int offset, input int dmax, input int dmin);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_DUTY_OFFSET;
        cfg_wdata <= DutyW'(offset);
        @(posedge aclk);
        cfg_addr  <= REG_DUTY_MAX;
        cfg_wdata <= DutyW'(dmax);
        @(posedge aclk);
        cfg_addr  <= REG_DUTY_MIN;
        cfg_wdata <= DutyW'(dmin);
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        cfg_offset = offset;
        cfg_max    = dmax;
        cfg_min    = dmin;
    endtask

    // ------------------------------------------------------------- result side

    initial begin : result_sink
        int gap;
        int holds_served;
        holds_served = 0;
        forever begin
            @(posedge aclk);
            if (hold_req != holds_served) begin
                m_ready <= 1'b0;
                repeat (HoldCycles) @(posedge aclk);
                holds_served++;
            end
            gap = rx_idle_en ? rand_gap() : 0;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    task automatic check_leg(input string leg, input logic [DutyW-1:0] got,
                             input logic [DutyW-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("request %0d %s: got %0d, expected %0d",
                                      results_seen, leg, got, want));
    endtask

    always @(posedge aclk) begin : result_check
        duty_set_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_duties.size() == 0) begin
                report_mismatch("result with no request pending");
            end else begin
                want = expected_duties.pop_front();
                check_leg("r_duty_pos", m_r_duty_pos, want.r_pos);
                check_leg("r_duty_neg", m_r_duty_neg, want.r_neg);
                check_leg("s_duty_pos", m_s_duty_pos, want.s_pos);
                check_leg("s_duty_neg", m_s_duty_neg, want.s_neg);
                check_leg("t_duty_pos", m_t_duty_pos, want.t_pos);
                check_leg("t_duty_neg", m_t_duty_neg, want.t_neg);
            end
            results_seen++;
        end
    end

    // -------------------------------------------------------------------- tests

    // register reset values, sign-change blanking, mode 3
    task automatic test_reset_values();
        send_fields(MODE_SINE, 0, 0, 0, 2048, 0, 0);
        send_fields(MODE_SINE, VoltMin, VoltMax, -1, GainMax, 0, 0);
        send_fields(MODE_SINE, VoltMin, VoltMax, -1, GainMax, 0, 0);
        send_fields(ModeSineAlt, VoltMin, VoltMax, -1, GainMax, InjMax, InjMin);
        close_phase();
    endtask

    task automatic test_field_extremes();
        send_fields(MODE_MINMAX, VoltMax, VoltMin, 0, GainMax, InjMax, InjMin);
        send_fields(MODE_MINMAX, VoltMin, VoltMax, VoltMax, GainMax, InjMin, InjMin);
        send_fields(MODE_MINMAX, 1234, -4321, 777, GainMax, InjMax, InjMax);
        send_fields(MODE_SINE, VoltMax, VoltMin, VoltMin, 0, InjMax, InjMax);
        send_fields(MODE_MINMAX, VoltMin, VoltMax, 5, 0, InjMin, InjMax);
        send_fields(MODE_MINMAX, VoltMin, VoltMin, VoltMin, GainMax, 100, -300);
        close_phase();
    endtask

    // equal magnitudes keep the earlier phase; large injections wrap 16 bits
    task automatic test_dpwm_ties();
        send_fields(MODE_DPWM, 1000, -1000, 0, GainMax, 0, 0);
        send_fields(MODE_DPWM, -1000, 1000, 500, GainMax, 0, 0);
        send_fields(MODE_DPWM, 0, 0, 0, GainMax, 0, 0);
        send_fields(MODE_DPWM, 0, 0, VoltMin, GainMax, 37, -37);
        send_fields(MODE_DPWM, VoltMax, 16000, -3000, GainMax, 0, InjMax);
        send_fields(MODE_DPWM, VoltMin, -16000, 3000, GainMax, InjMin, 0);
        close_phase();
    endtask

    task automatic test_clamp_limits();
        set_config(OffMax, DutyMax, 0);
        send_fields(MODE_SINE, VoltMax, VoltMin, 300, GainMax, 0, 0);
        send_fields(MODE_SINE, VoltMax, VoltMin, 300, GainMax, 0, 0);
        close_phase();
        set_config(0, 0, 0);
        send_fields(MODE_DPWM, 9000, -2000, 40, GainMax, 0, 0);
        close_phase();
        // min above max: min wins
        set_config(500, 1000, 2000);
        send_fields(MODE_SINE, -9000, 9000, 0, GainMax, 0, 0);
        send_fields(MODE_SINE, -9000, 9000, 0, GainMax, 0, 0);
        close_phase();
        set_config(OffMax, DutyMax, DutyMax);
        send_fields(MODE_MINMAX, 4000, -4000, 100, GainMax, 50, -50);
        close_phase();
    endtask

    // sink stalls for a long stretch while requests keep coming
    task automatic test_backpressure();
        set_config(OffsetReset, MaxReset, MinReset);
        tx_idle_en = 1'b0;
        hold_req <= hold_req + 1;
        for (int i = 0; i < 48; i++) send_req(random_req());
        close_phase();
        tx_idle_en = 1'b1;
    endtask

    task automatic test_random_traffic();
        int offset, dmax, dmin;
        for (int ph = 0; ph < PhaseCount; ph++) begin
            case (ph)
                0: begin offset = OffMax; dmax = DutyMax; dmin = 0; end
                1: begin offset = 0;      dmax = 9000;    dmin = 0; end
                default: begin
                    case ($urandom_range(0, 2))
                        0:       offset = 0;
                        1:       offset = OffMax;
                        default: offset = $urandom_range(0, OffMax);
                    endcase
                    dmax = ($urandom_range(0, 2) == 0) ? DutyMax : $urandom_range(0, DutyMax);
                    case ($urandom_range(0, 3))
                        0:       dmin = 0;
                        1:       dmin = $urandom_range(0, DutyMax);
                        default: dmin = $urandom_range(0, 3000);
                    endcase
                end
            endcase
            set_config(offset, dmax, dmin);
            // phase 2 runs back to back on both sides, phase 4 with an eager sink
            tx_idle_en = (ph != 2);
            rx_idle_en <= (ph != 2 && ph != 4);
            for (int i = 0; i < PhaseItems; i++) send_req(random_req());
            close_phase();
        end
        tx_idle_en = 1'b1;
        rx_idle_en <= 1'b1;
    endtask

    initial begin
        repeat (LimitCycles) @(posedge aclk);
        $display("[three_phase_pwm_duty_modulator_top] ERROR");
        $finish;
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_values();
        test_field_extremes();
        test_dpwm_ties();
        test_clamp_limits();
        test_backpressure();
        test_random_traffic();
        if (err_count == 0) begin
            $display("[three_phase_pwm_duty_modulator_top] OK");
        end else begin
            $display("[three_phase_pwm_duty_modulator_top] ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/tpdm_pkg.sv
rtl/tpdm_scale_lane.sv
rtl/tpdm_merge.sv
rtl/tpdm_split_lane.sv
rtl/three_phase_pwm_duty_modulator_top.sv
bench/tb_top.sv
